/* hw/rtl/rmq_pkg.sv */
// ----------------------------------------------------------------------------
// rmq_pkg
// Shared widths and types for the rotation matrix to quaternion pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package rmq_pkg;

  // element format: signed, two integer bits
  localparam int DATA_WIDTH = 16;
  localparam int FRAC       = DATA_WIDTH - 2;

  // matrix trace and square-root argument
  localparam int TW    = DATA_WIDTH + 2;
  localparam int ASW   = DATA_WIDTH + 3;
  localparam int AW    = DATA_WIDTH + 1;

  // square root: radicand is the argument shifted up by FRAC
  localparam int RADW  = AW + FRAC;
  localparam int SW    = (RADW + 1) / 2;
  localparam int RAD2  = 2 * SW;
  localparam int REMW  = SW + 3;

  // numerators and the rounding divider
  localparam int NUMW  = DATA_WIDTH + 1;
  localparam int NW    = DATA_WIDTH + FRAC + 1;
  localparam int DW    = SW + 1;
  localparam int QW    = NW - FRAC / 2 - 1;

  // stream widths, whole bytes
  localparam int IN_W  = ((9 * DATA_WIDTH + 7) / 8) * 8;
  localparam int OUT_W = ((4 * DATA_WIDTH + 7) / 8) * 8;

  typedef logic signed [DATA_WIDTH-1:0] elem_t;
  typedef logic signed [NUMW-1:0]       num_t;

  // quaternion component slots
  typedef enum logic [1:0] {
    SLOT_X = 2'd0,
    SLOT_Y = 2'd1,
    SLOT_Z = 2'd2,
    SLOT_W = 2'd3
  } slot_t;

endpackage

`default_nettype wire

/* hw/rtl/rmq_div_pipe.sv */
// ----------------------------------------------------------------------------
// rmq_div_pipe
// Pipelined restoring divider, one quotient bit per stage, shared stall.
// ----------------------------------------------------------------------------
`default_nettype none

module rmq_div_pipe (
  input  logic                  clk,
  input  logic                  en,
  input  logic [rmq_pkg::NW-1:0] num,
  input  logic [rmq_pkg::DW-1:0] den,
  output logic [rmq_pkg::QW-1:0] quot
);
  import rmq_pkg::*;

  logic [DW-1:0] rem   [QW+1];
  logic [QW-1:0] lo    [QW+1];
  logic [DW-1:0] den_r [QW+1];

  logic [DW-1:0] rem_nx [QW+1];
  logic [QW-1:0] lo_nx  [QW+1];

  // one trial subtraction per stage; top dividend bits are known below den
  always_comb begin
    logic [DW:0] trial;
    rem_nx[0] = DW'(num[NW-1:QW]);
    lo_nx[0]  = num[QW-1:0];
    trial     = '0;
    for (int k = 1; k <= QW; k++) begin
      trial = {rem[k-1], lo[k-1][QW-1]};
      if (trial >= {1'b0, den_r[k-1]}) begin
        rem_nx[k] = DW'(trial - {1'b0, den_r[k-1]});
        lo_nx[k]  = {lo[k-1][QW-2:0], 1'b1};
      end else begin
        rem_nx[k] = trial[DW-1:0];
        lo_nx[k]  = {lo[k-1][QW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      den_r[0] <= den;
      for (int k = 0; k <= QW; k++) begin
        rem[k] <= rem_nx[k];
        lo[k]  <= lo_nx[k];
        if (k > 0) den_r[k] <= den_r[k-1];
      end
    end
  end

  assign quot = lo[QW];

endmodule

`default_nettype wire

/* hw/rtl/rotation_matrix_to_quaternion.sv */
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion
// Fixed-point 3x3 rotation matrix to quaternion, fully pipelined.
// ----------------------------------------------------------------------------
// One matrix beat is taken every cycle and one quaternion beat leaves every
// cycle while the output beat is taken. The pipeline is two front stages
// for the trace, branch choice and numerators, one stage per root bit of the
// square root, a load stage and one stage per quotient bit of the four
// rounding dividers, and the saturating output register. The whole pipeline
// holds when the output beat is not taken. A degenerate matrix gives zero components with tuser set.
`default_nettype none

module rotation_matrix_to_quaternion (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     s_axis_tvalid,
  output logic                     s_axis_tready,
  // m_0_0, m_0_1, m_0_2, m_1_0, m_1_1, m_1_2, m_2_0, m_2_1, m_2_2
  input  logic [rmq_pkg::IN_W-1:0]  s_axis_tdata,
  output logic                     m_axis_tvalid,
  input  logic                     m_axis_tready,
  // quat_x, quat_y, quat_z, quat_w
  output logic [rmq_pkg::OUT_W-1:0] m_axis_tdata,
  // degenerate
  output logic [0:0]               m_axis_tuser
);
  import rmq_pkg::*;

  logic en;
  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  // unpack input beat
  elem_t m_in [3][3];
  always_comb begin
    for (int r = 0; r < 3; r++)
      for (int c = 0; c < 3; c++)
        m_in[r][c] = s_axis_tdata[(r*3+c)*DATA_WIDTH +: DATA_WIDTH];
  end

  // stage 1: trace and largest diagonal element
  logic                 v1;
  elem_t                m1 [3][3];
  logic signed [TW-1:0] t1;
  logic [1:0]           i1;

  logic signed [TW-1:0] t_in;
  logic [1:0]           i_in;
  always_comb begin
    t_in = TW'(m_in[0][0]) + TW'(m_in[1][1]) + TW'(m_in[2][2]);
    if (m_in[0][0] < m_in[1][1]) i_in = (m_in[1][1] < m_in[2][2]) ? 2'd2 : 2'd1;
    else                         i_in = (m_in[0][0] < m_in[2][2]) ? 2'd2 : 2'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m1 <= m_in;
      t1 <= t_in;
      i1 <= i_in;
    end
  end

  // stage 2 feeds sqrt slot 0: argument, numerators, main slot
  logic [RAD2-1:0] sq_rad  [SW+1];
  logic [REMW-1:0] sq_rem  [SW+1];
  logic [SW-1:0]   sq_root [SW+1];
  num_t            sq_num  [SW+1][4];
  slot_t           sq_main [SW+1];
  logic            sq_dgn  [SW+1];
  logic            sq_v    [SW+1];

  logic signed [ASW-1:0] a2;
  logic [AW-1:0]         rad2;
  logic                  dgn2;
  num_t                  num2 [4];
  slot_t                 main2;

  function automatic num_t nadd(elem_t p, elem_t q);
    return NUMW'(p) + NUMW'(q);
  endfunction

  function automatic num_t nsub(elem_t p, elem_t q);
    return NUMW'(p) - NUMW'(q);
  endfunction

  always_comb begin
    for (int c = 0; c < 4; c++) num2[c] = '0;
    if (t1 > 0) begin
      a2            = ASW'(t1) + ASW'(1 << FRAC);
      main2         = SLOT_W;
      num2[SLOT_X]  = nsub(m1[1][2], m1[2][1]);
      num2[SLOT_Y]  = nsub(m1[2][0], m1[0][2]);
      num2[SLOT_Z]  = nsub(m1[0][1], m1[1][0]);
    end else begin
      unique case (i1)
        2'd0: begin
          a2           = ASW'(m1[0][0]) - ASW'(m1[1][1]) - ASW'(m1[2][2])
                         + ASW'(1 << FRAC);
          main2        = SLOT_X;
          num2[SLOT_W] = nsub(m1[1][2], m1[2][1]);
          num2[SLOT_Y] = nadd(m1[0][1], m1[1][0]);
          num2[SLOT_Z] = nadd(m1[0][2], m1[2][0]);
        end
        2'd1: begin
          a2           = ASW'(m1[1][1]) - ASW'(m1[2][2]) - ASW'(m1[0][0])
                         + ASW'(1 << FRAC);
          main2        = SLOT_Y;
          num2[SLOT_W] = nsub(m1[2][0], m1[0][2]);
          num2[SLOT_Z] = nadd(m1[1][2], m1[2][1]);
          num2[SLOT_X] = nadd(m1[1][0], m1[0][1]);
        end
        default: begin
          a2           = ASW'(m1[2][2]) - ASW'(m1[0][0]) - ASW'(m1[1][1])
                         + ASW'(1 << FRAC);
          main2        = SLOT_Z;
          num2[SLOT_W] = nsub(m1[0][1], m1[1][0]);
          num2[SLOT_X] = nadd(m1[2][0], m1[0][2]);
          num2[SLOT_Y] = nadd(m1[2][1], m1[1][2]);
        end
      endcase
    end
    dgn2 = (a2 <= 0);
    rad2 = dgn2 ? '0 : a2[AW-1:0];
  end

  // square root, one root bit per stage
  logic [RAD2-1:0] rad_nx  [SW+1];
  logic [REMW-1:0] rem_nx  [SW+1];
  logic [SW-1:0]   root_nx [SW+1];

  always_comb begin
    logic [REMW-1:0] remsh;
    logic [REMW-1:0] trial;
    rad_nx[0]  = {{(RAD2-RADW){1'b0}}, rad2, {FRAC{1'b0}}};
    rem_nx[0]  = '0;
    root_nx[0] = '0;
    remsh      = '0;
    trial      = '0;
    for (int k = 1; k <= SW; k++) begin
      remsh     = {sq_rem[k-1][REMW-3:0], sq_rad[k-1][RAD2-1 -: 2]};
      trial     = REMW'({sq_root[k-1], 2'b01});
      rad_nx[k] = {sq_rad[k-1][RAD2-3:0], 2'b00};
      if (remsh >= trial) begin
        rem_nx[k]  = remsh - trial;
        root_nx[k] = {sq_root[k-1][SW-2:0], 1'b1};
      end else begin
        rem_nx[k]  = remsh;
        root_nx[k] = {sq_root[k-1][SW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= SW; k++) sq_v[k] <= 1'b0;
    end else if (en) begin
      sq_v[0] <= v1;
      for (int k = 1; k <= SW; k++) sq_v[k] <= sq_v[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq_num[0]  <= num2;
      sq_main[0] <= main2;
      sq_dgn[0]  <= dgn2;
      for (int k = 0; k <= SW; k++) begin
        sq_rad[k]  <= rad_nx[k];
        sq_rem[k]  <= rem_nx[k];
        sq_root[k] <= root_nx[k];
        if (k > 0) begin
          sq_num[k]  <= sq_num[k-1];
          sq_main[k] <= sq_main[k-1];
          sq_dgn[k]  <= sq_dgn[k-1];
        end
      end
    end
  end

  // rounding dividers: (|D| << FRAC + S) / 2S
  logic [SW-1:0] s_fin;
  logic [DW-1:0] div_den;
  logic [NW-1:0] div_num [4];
  logic          neg_in  [4];
  logic [QW-1:0] quot    [4];

  always_comb begin
    logic [NUMW-1:0] mag;
    s_fin   = sq_root[SW];
    div_den = {s_fin, 1'b0};
    mag     = '0;
    for (int c = 0; c < 4; c++) begin
      neg_in[c]  = sq_num[SW][c][NUMW-1];
      mag        = neg_in[c] ? NUMW'(-sq_num[SW][c]) : NUMW'(sq_num[SW][c]);
      div_num[c] = (NW'(mag) << FRAC) + NW'(s_fin);
    end
  end

  for (genvar g = 0; g < 4; g++) begin : g_div
    rmq_div_pipe u_div (
      .clk  (clk),
      .en   (en),
      .num  (div_num[g]),
      .den  (div_den),
      .quot (quot[g])
    );
  end

  // side data alongside the dividers
  logic          dl_v    [QW+1];
  logic          dl_neg  [QW+1][4];
  logic [SW-2:0] dl_half [QW+1];
  slot_t         dl_main [QW+1];
  logic          dl_dgn  [QW+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= QW; k++) dl_v[k] <= 1'b0;
    end else if (en) begin
      dl_v[0] <= sq_v[SW];
      for (int k = 1; k <= QW; k++) dl_v[k] <= dl_v[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dl_neg[0]  <= neg_in;
      dl_half[0] <= s_fin[SW-1:1];
      dl_main[0] <= sq_main[SW];
      dl_dgn[0]  <= sq_dgn[SW];
      for (int k = 1; k <= QW; k++) begin
        dl_neg[k]  <= dl_neg[k-1];
        dl_half[k] <= dl_half[k-1];
        dl_main[k] <= dl_main[k-1];
        dl_dgn[k]  <= dl_dgn[k-1];
      end
    end
  end

  // output stage: sign, saturate, place main component
  logic  out_v;
  elem_t out_q [4];
  logic  out_dgn;
  elem_t q_nx  [4];

  localparam logic [QW-1:0] QMAX = QW'((1 << (DATA_WIDTH - 1)) - 1);
  localparam logic [QW-1:0] QMIN = QW'(1 << (DATA_WIDTH - 1));

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      if (dl_dgn[QW]) begin
        q_nx[c] = '0;
      end else if (dl_main[QW] == slot_t'(c)) begin
        q_nx[c] = DATA_WIDTH'(dl_half[QW]);
      end else if (dl_neg[QW][c]) begin
        q_nx[c] = (quot[c] > QMIN) ? elem_t'(QMIN[DATA_WIDTH-1:0])
                                   : elem_t'(-quot[c][DATA_WIDTH-1:0]);
      end else begin
        q_nx[c] = (quot[c] > QMAX) ? elem_t'(QMAX[DATA_WIDTH-1:0])
                                   : elem_t'(quot[c][DATA_WIDTH-1:0]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_v <= 1'b0;
    end else if (en) begin
      out_v <= dl_v[QW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_q   <= q_nx;
      out_dgn <= dl_dgn[QW];
    end
  end

  // pack output beat
  assign m_axis_tvalid = out_v;
  assign m_axis_tuser  = out_dgn;
  always_comb begin
    m_axis_tdata = '0;
    for (int c = 0; c < 4; c++)
      m_axis_tdata[c*DATA_WIDTH +: DATA_WIDTH] = out_q[c];
  end

endmodule

`default_nettype wire
